[hdl/swef_pkg.sv]
// Shared types, constants and fixed-point helpers of the slip-wall flux block.
package swef_pkg;

  localparam int MIX_BITS  = 16;
  localparam int DIV_STEPS = 31;
  localparam int QPTR_W    = 2;
  localparam int QDEPTH    = 1 << QPTR_W;

  typedef logic signed [31:0] word_t;

  localparam word_t WMAX = 32'sh7fff_ffff;
  localparam word_t WMIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_MIX,
    REG_GAMMA,
    REG_DT,
    REG_MOVING
  } reg_idx_e;

  typedef struct packed {
    word_t rho;
    word_t mx;
    word_t my;
    word_t en;
  } state_t;

  // face as it arrives on the ports
  typedef struct packed {
    state_t [1:0] st;
    word_t        nx;
    word_t        ny;
    word_t        wsx;
    word_t        wsy;
  } face_t;

  // classified face as it sits in the queue
  typedef struct packed {
    state_t [1:0] st;
    word_t        nx;
    word_t        ny;
    word_t        wall;
    logic         fault;
  } item_t;

  typedef struct packed {
    logic [16:0] mix;
    logic [17:0] gam;
    logic [30:0] dt;
    logic        moving;
  } cfg_t;

  typedef struct packed {
    logic [1:0][3:0][31:0] delta;
    logic                  fault;
  } res_t;

  function automatic word_t sat64(input logic signed [63:0] x);
    if (x > 64'(WMAX)) return WMAX;
    if (x < 64'(WMIN)) return WMIN;
    return x[31:0];
  endfunction

  // shift right, round half away from zero, saturate
  function automatic word_t rsat(input logic signed [63:0] p, input int sh);
    logic signed [63:0] r;
    r = (p + (64'sd1 <<< (sh - 1)) - (p[63] ? 64'sd1 : 64'sd0)) >>> sh;
    return sat64(r);
  endfunction

  // same rounding, negated before saturation
  function automatic word_t negrnd(input logic signed [63:0] p, input int sh);
    logic signed [63:0] r;
    r = (p + (64'sd1 <<< (sh - 1)) - (p[63] ? 64'sd1 : 64'sd0)) >>> sh;
    return sat64(-r);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return sat64(s);
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return sat64(s);
  endfunction

endpackage

[hdl/swef_front.sv]
// Front end: takes faces, forms the wall term and flags nonpositive densities.
module swef_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swef_pkg::face_t      face_i,
  input  logic                 full_i,
  output logic                 push_o,
  output swef_pkg::item_t      item_o
);

  logic                adv;
  logic                f1v_q, f2v_q;
  swef_pkg::face_t     f1_q;
  logic signed [63:0]  pwx_q, pwy_q;
  swef_pkg::item_t     f2_q;

  assign adv        = !f2v_q || !full_i;
  assign push_o     = f2v_q && !full_i;
  assign in_ready_o = adv;
  assign item_o     = f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1v_q <= 1'b0;
      f2v_q <= 1'b0;
    end else if (adv) begin
      f1v_q <= in_valid_i;
      f2v_q <= f1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q       <= face_i;
      pwx_q      <= face_i.nx * face_i.wsx;
      pwy_q      <= face_i.ny * face_i.wsy;
      f2_q.st    <= f1_q.st;
      f2_q.nx    <= f1_q.nx;
      f2_q.ny    <= f1_q.ny;
      f2_q.wall  <= swef_pkg::sadd(swef_pkg::rsat(pwx_q, FRAC_BITS),
                                   swef_pkg::rsat(pwy_q, FRAC_BITS));
      f2_q.fault <= f1_q.st[0].rho[31] || (f1_q.st[0].rho == '0) ||
                    f1_q.st[1].rho[31] || (f1_q.st[1].rho == '0);
    end
  end

endmodule

[hdl/swef_fifo.sv]
// Short queue between front end and flux pipeline.
module swef_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  swef_pkg::item_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output swef_pkg::item_t  item_o,
  output logic             empty_o
);

  localparam int PW = swef_pkg::QPTR_W;

  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;
  swef_pkg::item_t  mem_q [swef_pkg::QDEPTH];

  assign full_o  = (cnt_q == (PW + 1)'(swef_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW + 1)'(swef_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_cnt_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && pop_i) |=> $stable(cnt_q))
    else $error("queue count moved on push with pop");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");

endmodule

[hdl/swef_div.sv]
// Pipelined radix-2 fixed-point divider giving velocity = momentum / density.
module swef_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  swef_pkg::word_t num_i,
  input  swef_pkg::word_t den_i,
  output swef_pkg::word_t quo_o
);

  localparam int NW    = 32 + FRAC_BITS;
  localparam int STEPS = swef_pkg::DIV_STEPS;

  typedef struct packed {
    logic [30:0] r;
    logic [30:0] nl;
    logic [30:0] d;
    logic [30:0] q;
    logic        neg;
    logic        ovf;
    logic        bad;
    logic        mpos;
    logic        mzero;
  } dst_t;

  dst_t            st_q [STEPS + 1];
  dst_t            st_d [STEPS + 1];
  logic [31:0]     mag;
  logic [NW-1:0]   nfull;
  logic [31:0]     sh;
  logic [32:0]     trial;
  swef_pkg::word_t quo_d, quo_q;

  always_comb begin
    // setup: |num| << FRAC_BITS plus half the divisor for rounding
    mag            = num_i[31] ? 32'(-num_i) : 32'(num_i);
    st_d[0].bad    = den_i[31] || (den_i == '0);
    st_d[0].d      = st_d[0].bad ? 31'd1 : den_i[30:0];
    nfull          = {mag, {FRAC_BITS{1'b0}}} + NW'(st_d[0].d >> 1);
    st_d[0].r      = 31'(nfull[NW-1:31]);
    st_d[0].nl     = nfull[30:0];
    st_d[0].q      = '0;
    st_d[0].neg    = num_i[31];
    st_d[0].ovf    = 1'b0;
    st_d[0].mpos   = !num_i[31] && (num_i != '0);
    st_d[0].mzero  = (num_i == '0);
    for (int k = 0; k < STEPS; k++) begin
      st_d[k+1]    = st_q[k];
      sh           = {st_q[k].r, st_q[k].nl[30]};
      trial        = {1'b0, sh} - {2'b00, st_q[k].d};
      st_d[k+1].r  = trial[32] ? sh[30:0] : trial[30:0];
      st_d[k+1].nl = st_q[k].nl << 1;
      st_d[k+1].q  = {st_q[k].q[29:0], !trial[32]};
      // quotient of 2^31 or more saturates
      if (k == 0) st_d[k+1].ovf = (st_q[k].r >= st_q[k].d);
    end
    if (st_q[STEPS].bad) begin
      if (st_q[STEPS].mpos) quo_d = swef_pkg::WMAX;
      else if (st_q[STEPS].mzero) quo_d = '0;
      else quo_d = swef_pkg::WMIN;
    end else if (st_q[STEPS].ovf) begin
      quo_d = st_q[STEPS].neg ? swef_pkg::WMIN : swef_pkg::WMAX;
    end else if (st_q[STEPS].neg) begin
      quo_d = -$signed({1'b0, st_q[STEPS].q});
    end else begin
      quo_d = $signed({1'b0, st_q[STEPS].q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

[hdl/swef_back.sv]
// Back end: flux pipeline for both states, dt scaling and the alpha mix.
module swef_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swef_pkg::cfg_t   cfg_i,
  input  logic             q_empty_i,
  input  swef_pkg::item_t  q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output swef_pkg::res_t   out_res_o
);

  localparam int DIV_LAT = swef_pkg::DIV_STEPS + 2;
  localparam int B       = DIV_LAT - 1;
  localparam int NV      = DIV_LAT + 11;
  localparam int MSH     = swef_pkg::MIX_BITS + 1;
  localparam logic signed [31:0] QONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [16:0] MIX_ONE = 17'(1 << swef_pkg::MIX_BITS);

  logic                adv, pop;
  logic [NV-1:0]       vq_q;
  swef_pkg::item_t     it_q [NV];
  swef_pkg::word_t     u_w [2];
  swef_pkg::word_t     v_w [2];
  logic signed [31:0]  g32, hx, hgm;
  logic [16:0]         a_eff;

  logic signed [63:0]  pux_q [2], pvy_q [2], puu_q [2], pvv_q [2], pge_q [2];
  swef_pkg::word_t     un2_q [2], vel2_q [2], ge2_q [2];
  logic signed [63:0]  prv_q [2];
  swef_pkg::word_t     un3_q [2], ge3_q [2];
  swef_pkg::word_t     rv2_q [2], un4_q [2], ge4_q [2];
  logic signed [63:0]  phr_q [2];
  swef_pkg::word_t     un5_q [2], ge5_q [2];
  swef_pkg::word_t     rh_q [2], un6_q [2];
  logic signed [63:0]  pf_q [2][4];
  logic signed [63:0]  pw_q [2][4];
  swef_pkg::word_t     f8_q [2][4];
  logic signed [63:0]  pt_q [2][4];
  swef_pkg::word_t     f10_q [2][4];
  logic signed [50:0]  pd_q [4];
  swef_pkg::word_t     f0_q [4], f1_q [4];
  swef_pkg::res_t      res_d, res_q;
  logic                ov_q;

  assign adv         = !ov_q || out_ready_i;
  assign pop         = adv && !q_empty_i;
  assign q_pop_o     = pop;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  for (genvar j = 0; j < 2; j++) begin : g_div
    swef_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (q_item_i.st[j].mx),
      .den_i (q_item_i.st[j].rho),
      .quo_o (u_w[j])
    );
    swef_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (q_item_i.st[j].my),
      .den_i (q_item_i.st[j].rho),
      .quo_o (v_w[j])
    );
  end

  always_comb begin
    g32   = $signed({14'd0, cfg_i.gam});
    hx    = g32 - QONE;
    // 0.5 * (gamma - 1), rounded half away from zero
    hgm   = (hx + (hx[31] ? 32'sd0 : 32'sd1)) >>> 1;
    a_eff = (cfg_i.mix > MIX_ONE) ? MIX_ONE : cfg_i.mix;
    res_d.fault = it_q[B+11].fault;
    for (int i = 0; i < 4; i++) begin
      res_d.delta[0][i] = swef_pkg::negrnd(
        64'(pd_q[i]) + (64'(f1_q[i]) <<< swef_pkg::MIX_BITS), MSH);
      res_d.delta[1][i] = swef_pkg::negrnd(
        -64'(pd_q[i]) + (64'(f0_q[i]) <<< swef_pkg::MIX_BITS), MSH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      vq_q <= {vq_q[NV-2:0], pop};
      ov_q <= vq_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[0] <= q_item_i;
      for (int k = 1; k < NV; k++) it_q[k] <= it_q[k-1];
      for (int j = 0; j < 2; j++) begin
        // products on velocity, and gamma*E
        pux_q[j]  <= u_w[j] * it_q[B].nx;
        pvy_q[j]  <= v_w[j] * it_q[B].ny;
        puu_q[j]  <= u_w[j] * u_w[j];
        pvv_q[j]  <= v_w[j] * v_w[j];
        pge_q[j]  <= g32 * it_q[B].st[j].en;
        // normal velocity, |v|^2, gamma*E
        un2_q[j]  <= swef_pkg::sadd(swef_pkg::rsat(pux_q[j], FRAC_BITS),
                                    swef_pkg::rsat(pvy_q[j], FRAC_BITS));
        vel2_q[j] <= swef_pkg::sadd(swef_pkg::rsat(puu_q[j], FRAC_BITS),
                                    swef_pkg::rsat(pvv_q[j], FRAC_BITS));
        ge2_q[j]  <= swef_pkg::rsat(pge_q[j], FRAC_BITS);
        prv_q[j]  <= it_q[B+2].st[j].rho * vel2_q[j];
        un3_q[j]  <= un2_q[j];
        ge3_q[j]  <= ge2_q[j];
        rv2_q[j]  <= swef_pkg::rsat(prv_q[j], FRAC_BITS);
        un4_q[j]  <= un3_q[j];
        ge4_q[j]  <= ge3_q[j];
        phr_q[j]  <= hgm * rv2_q[j];
        un5_q[j]  <= un4_q[j];
        ge5_q[j]  <= ge4_q[j];
        // rhoH
        rh_q[j]   <= swef_pkg::ssub(ge5_q[j], swef_pkg::rsat(phr_q[j], FRAC_BITS));
        un6_q[j]  <= un5_q[j];
        pf_q[j][0] <= un6_q[j] * it_q[B+6].st[j].rho;
        pf_q[j][1] <= un6_q[j] * it_q[B+6].st[j].mx;
        pf_q[j][2] <= un6_q[j] * it_q[B+6].st[j].my;
        pf_q[j][3] <= un6_q[j] * rh_q[j];
        pw_q[j][0] <= it_q[B+6].st[j].rho * it_q[B+6].wall;
        pw_q[j][1] <= it_q[B+6].st[j].mx * it_q[B+6].wall;
        pw_q[j][2] <= it_q[B+6].st[j].my * it_q[B+6].wall;
        pw_q[j][3] <= rh_q[j] * it_q[B+6].wall;
        for (int i = 0; i < 4; i++) begin
          f8_q[j][i]  <= cfg_i.moving ?
                         swef_pkg::sadd(swef_pkg::rsat(pf_q[j][i], FRAC_BITS),
                                        swef_pkg::rsat(pw_q[j][i], FRAC_BITS)) :
                         swef_pkg::rsat(pf_q[j][i], FRAC_BITS);
          pt_q[j][i]  <= f8_q[j][i] * $signed({1'b0, cfg_i.dt});
          f10_q[j][i] <= swef_pkg::rsat(pt_q[j][i], FRAC_BITS);
        end
      end
      // alpha*(F1 - F2): one product serves both nodes
      for (int i = 0; i < 4; i++) begin
        pd_q[i] <= $signed({1'b0, a_eff}) * (51'(f10_q[0][i]) - 51'(f10_q[1][i]));
        f0_q[i] <= f10_q[0][i];
        f1_q[i] <= f10_q[1][i];
      end
      res_q <= res_d;
    end
  end

  a_hold_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vq_q))
    else $error("pipeline valid line moved during stall");

endmodule

[hdl/slip_wall_euler_flux_split.sv]
// Top level of the slip-wall Euler normal-flux splitter with its register port.
// Throughput: one item per cycle when the output is not stalled; the pipelined
// dividers (31 quotient-bit stages plus setup and output registers) and the
// multiply stages behind them each take a new item every cycle.
// Reset (rst_ni low, asynchronous) empties every stage and the queue and loads
// the registers with their defaults: alpha 1.0, gamma 1.4, dt 1.0, fixed wall.
module slip_wall_euler_flux_split #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // face input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] first_density_i,
  input  logic signed [31:0] first_momentum_x_i,
  input  logic signed [31:0] first_momentum_y_i,
  input  logic signed [31:0] first_energy_i,
  input  logic signed [31:0] second_density_i,
  input  logic signed [31:0] second_momentum_x_i,
  input  logic signed [31:0] second_momentum_y_i,
  input  logic signed [31:0] second_energy_i,
  input  logic signed [31:0] normal_x_i,
  input  logic signed [31:0] normal_y_i,
  input  logic signed [31:0] wall_speed_x_i,
  input  logic signed [31:0] wall_speed_y_i,
  // residual output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] first_mass_delta_o,
  output logic signed [31:0] first_xmom_delta_o,
  output logic signed [31:0] first_ymom_delta_o,
  output logic signed [31:0] first_energy_delta_o,
  output logic signed [31:0] second_mass_delta_o,
  output logic signed [31:0] second_xmom_delta_o,
  output logic signed [31:0] second_ymom_delta_o,
  output logic signed [31:0] second_energy_delta_o,
  output logic               density_fault_o
);

  swef_pkg::cfg_t   cfg_q;
  swef_pkg::face_t  face;
  swef_pkg::item_t  f_item, q_item;
  swef_pkg::res_t   res;
  logic             push, full, pop, empty;
  logic             cfg_wr;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mix    <= 17'd65536;
      cfg_q.gam    <= 18'd91750;
      cfg_q.dt     <= 31'd65536;
      cfg_q.moving <= 1'b0;
    end else if (cfg_wr) begin
      unique case (swef_pkg::reg_idx_e'(paddr[3:2]))
        swef_pkg::REG_MIX:    cfg_q.mix    <= pwdata[16:0];
        swef_pkg::REG_GAMMA:  cfg_q.gam    <= pwdata[17:0];
        swef_pkg::REG_DT:     cfg_q.dt     <= pwdata[30:0];
        swef_pkg::REG_MOVING: cfg_q.moving <= pwdata[0];
        default:              cfg_q        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (swef_pkg::reg_idx_e'(paddr[3:2]))
      swef_pkg::REG_MIX:    prdata = 32'(cfg_q.mix);
      swef_pkg::REG_GAMMA:  prdata = 32'(cfg_q.gam);
      swef_pkg::REG_DT:     prdata = 32'(cfg_q.dt);
      swef_pkg::REG_MOVING: prdata = 32'(cfg_q.moving);
      default:              prdata = '0;
    endcase
  end

  // ---------------- face in ----------------
  always_comb begin
    face.st[0].rho = first_density_i;
    face.st[0].mx  = first_momentum_x_i;
    face.st[0].my  = first_momentum_y_i;
    face.st[0].en  = first_energy_i;
    face.st[1].rho = second_density_i;
    face.st[1].mx  = second_momentum_x_i;
    face.st[1].my  = second_momentum_y_i;
    face.st[1].en  = second_energy_i;
    face.nx        = normal_x_i;
    face.ny        = normal_y_i;
    face.wsx       = wall_speed_x_i;
    face.wsy       = wall_speed_y_i;
  end

  // front end: wall term and density check, two stages
  swef_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .face_i     (face),
    .full_i     (full),
    .push_o     (push),
    .item_o     (f_item)
  );

  // decouples front end from the flux pipeline
  swef_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (q_item),
    .empty_o (empty)
  );

  // velocities, fluxes, dt scaling, mix; output register at its end
  swef_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (empty),
    .q_item_i    (q_item),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  // ---------------- residual out ----------------
  assign first_mass_delta_o    = res.delta[0][0];
  assign first_xmom_delta_o    = res.delta[0][1];
  assign first_ymom_delta_o    = res.delta[0][2];
  assign first_energy_delta_o  = res.delta[0][3];
  assign second_mass_delta_o   = res.delta[1][0];
  assign second_xmom_delta_o   = res.delta[1][1];
  assign second_ymom_delta_o   = res.delta[1][2];
  assign second_energy_delta_o = res.delta[1][3];
  assign density_fault_o       = res.fault;

endmodule

[test/tb.sv]
// Testbench for the slip-wall Euler normal-flux splitter.
`timescale 1ns / 1ps
module tb;

  // One face as offered on the input ports.
  typedef struct {
    logic signed [31:0] st [2][4];  // node, then rho / rhoU / rhoV / rhoE
    logic signed [31:0] nx, ny, wsx, wsy;
  } face_in_t;

  // One residual item as seen on the output ports.
  typedef struct {
    logic signed [31:0] dl [2][4];
    logic               fault;
  } resid_t;

  localparam int FRAC     = 16;
  localparam int WDOG_MAX = 20000;
  localparam int LATENCY  = 47;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] f_rho0 = '0, f_mx0 = '0, f_my0 = '0, f_en0 = '0;
  logic signed [31:0] f_rho1 = '0, f_mx1 = '0, f_my1 = '0, f_en1 = '0;
  logic signed [31:0] f_nx = '0, f_ny = '0, f_wsx = '0, f_wsy = '0;

  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] o_m0, o_x0, o_y0, o_e0, o_m1, o_x1, o_y1, o_e1;
  logic o_fault;

  slip_wall_euler_flux_split dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .first_density_i(f_rho0), .first_momentum_x_i(f_mx0),
    .first_momentum_y_i(f_my0), .first_energy_i(f_en0),
    .second_density_i(f_rho1), .second_momentum_x_i(f_mx1),
    .second_momentum_y_i(f_my1), .second_energy_i(f_en1),
    .normal_x_i(f_nx), .normal_y_i(f_ny),
    .wall_speed_x_i(f_wsx), .wall_speed_y_i(f_wsy),
    .out_valid_o, .out_ready_i,
    .first_mass_delta_o(o_m0), .first_xmom_delta_o(o_x0),
    .first_ymom_delta_o(o_y0), .first_energy_delta_o(o_e0),
    .second_mass_delta_o(o_m1), .second_xmom_delta_o(o_x1),
    .second_ymom_delta_o(o_y1), .second_energy_delta_o(o_e1),
    .density_fault_o(o_fault)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the register file, updated when a write is issued.
  logic [16:0] sh_alpha  = 17'd65536;
  logic [17:0] sh_gamma  = 18'd91750;
  logic [30:0] sh_dt     = 31'd65536;
  logic        sh_moving = 1'b0;

  // Idle and stall rates in percent; the receiver hold-off is separate.
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_cycles = 0;

  resid_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;

  // ---------------------------------------------------------------------
  // Fixed-point predictor. All math in 64 bits, then saturated.
  // ---------------------------------------------------------------------
  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // divide by 2^sh, round half away from zero
  function automatic longint round_shift(longint p, int sh);
    longint unsigned m;
    m = (p < 0) ? -p : p;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clamp32(round_shift(a * b, FRAC));
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp32(a + b);
  endfunction

  // velocity = momentum / density with the nonpositive-density rule
  function automatic longint fx_velocity(longint mom, longint rho);
    longint unsigned n, q;
    if (rho <= 0) return (mom > 0) ? 64'sd2147483647 :
                         (mom < 0) ? -64'sd2147483648 : 64'sd0;
    n = ((mom < 0) ? -mom : mom) << FRAC;
    q = (n + rho / 2) / rho;
    if (q > 64'd2147483648) q = 64'd2147483648;
    return clamp32((mom < 0) ? -longint'(q) : longint'(q));
  endfunction

  // normal flux of one node state, already scaled by dt
  function automatic void node_flux(input longint s[4], input longint nx, ny, wall,
                                    output longint fl[4]);
    longint u, v, un, hgm, vel2, rv2, rh, g;
    longint q[4];
    g    = sh_gamma;
    u    = fx_velocity(s[1], s[0]);
    v    = fx_velocity(s[2], s[0]);
    un   = fx_add(fx_mul(u, nx), fx_mul(v, ny));
    hgm  = fx_mul(64'sd1 << (FRAC - 1), g - (64'sd1 << FRAC));
    vel2 = fx_add(fx_mul(u, u), fx_mul(v, v));
    rv2  = fx_mul(s[0], vel2);
    rh   = clamp32(fx_mul(g, s[3]) - fx_mul(hgm, rv2));
    q = '{s[0], s[1], s[2], rh};
    for (int i = 0; i < 4; i++) begin
      fl[i] = fx_mul(un, q[i]);
      if (sh_moving) fl[i] = fx_add(fl[i], fx_mul(q[i], wall));
      fl[i] = fx_mul(fl[i], longint'(sh_dt));
    end
  endfunction

  function automatic resid_t predict_residual(face_in_t fc);
    resid_t r;
    longint s0[4], s1[4], f0[4], f1[4];
    longint wall, a;
    for (int i = 0; i < 4; i++) begin
      s0[i] = fc.st[0][i];
      s1[i] = fc.st[1][i];
    end
    wall = fx_add(fx_mul(fc.nx, fc.wsx), fx_mul(fc.ny, fc.wsy));
    node_flux(s0, fc.nx, fc.ny, wall, f0);
    node_flux(s1, fc.nx, fc.ny, wall, f1);
    a = (sh_alpha > 17'd65536) ? 64'sd65536 : longint'(sh_alpha);
    for (int i = 0; i < 4; i++) begin
      // products stay within 2^47, so the mix fits in 64 bits
      r.dl[0][i] = 32'(clamp32(-round_shift(a * f0[i] + (65536 - a) * f1[i], 17)));
      r.dl[1][i] = 32'(clamp32(-round_shift(a * f1[i] + (65536 - a) * f0[i], 17)));
    end
    r.fault = (s0[0] <= 0) || (s1[0] <= 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(swef_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(int'(idx) * 4); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      swef_pkg::REG_MIX:    sh_alpha  = val[16:0];
      swef_pkg::REG_GAMMA:  sh_gamma  = val[17:0];
      swef_pkg::REG_DT:     sh_dt     = val[30:0];
      swef_pkg::REG_MOVING: sh_moving = val[0];
      default: ;
    endcase
  endtask

  // send one face; the caller is at a falling edge. Valid drops only in an
  // idle cycle or in drain, so items can follow back to back.
  task automatic send_face(face_in_t fc);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {f_rho0, f_mx0, f_my0, f_en0} <= {fc.st[0][0], fc.st[0][1], fc.st[0][2], fc.st[0][3]};
    {f_rho1, f_mx1, f_my1, f_en1} <= {fc.st[1][0], fc.st[1][1], fc.st[1][2], fc.st[1][3]};
    {f_nx, f_ny, f_wsx, f_wsy} <= {fc.nx, fc.ny, fc.wsx, fc.wsy};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.insert(expected_q.size(), predict_residual(fc));
    @(negedge clk_i);
  endtask

  // wait until every expected item has come, then let the pipe drain
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(131072)) - 65536);
      3: return 32'($urandom_range(4 << 16));
      default: return $urandom();
    endcase
  endfunction

  // mostly physical faces: positive density, modest momenta, unit-ish normal
  function automatic face_in_t rand_face();
    face_in_t fc;
    bit wild;
    wild = ($urandom_range(99) < 20);
    for (int n = 0; n < 2; n++) begin
      if (wild) begin
        for (int i = 0; i < 4; i++) fc.st[n][i] = rand_word();
      end else begin
        fc.st[n][0] = 32'($urandom_range(1 << 20, 1 << 12));
        fc.st[n][1] = 32'(int'($urandom_range(1 << 21)) - (1 << 20));
        fc.st[n][2] = 32'(int'($urandom_range(1 << 21)) - (1 << 20));
        fc.st[n][3] = 32'($urandom_range(1 << 23));
      end
    end
    fc.nx  = wild ? rand_word() : 32'(int'($urandom_range(1 << 17)) - (1 << 16));
    fc.ny  = wild ? rand_word() : 32'(int'($urandom_range(1 << 17)) - (1 << 16));
    fc.wsx = wild ? rand_word() : 32'(int'($urandom_range(1 << 18)) - (1 << 17));
    fc.wsy = wild ? rand_word() : 32'(int'($urandom_range(1 << 18)) - (1 << 17));
    return fc;
  endfunction

  function automatic face_in_t uniform_face(logic [31:0] v);
    face_in_t fc;
    for (int n = 0; n < 2; n++)
      for (int i = 0; i < 4; i++) fc.st[n][i] = v;
    fc.nx = v; fc.ny = v; fc.wsx = v; fc.wsy = v;
    return fc;
  endfunction

  // ---------------------------------------------------------------------
  // Output side: stall pattern, long hold-off, and the checker.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    resid_t got, exp_r;
    bit bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.dl[0] = '{o_m0, o_x0, o_y0, o_e0};
      got.dl[1] = '{o_m1, o_x1, o_y1, o_e1};
      got.fault = o_fault;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected residual item at %0t", $realtime);
      end else begin
        exp_r = expected_q.pop_front();
        bad = (got.fault !== exp_r.fault);
        for (int n = 0; n < 2; n++)
          for (int i = 0; i < 4; i++)
            if (got.dl[n][i] !== exp_r.dl[n][i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp %p fault %b, got %p fault %b", $realtime,
                     exp_r.dl, exp_r.fault, got.dl, got.fault);
        end
      end
    end
  end

  // watchdog on cycles without any handshake or register access
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed;
    face_in_t fc;
    // extremes of every field
    send_face(uniform_face(32'h0000_0000));
    send_face(uniform_face(32'h7fff_ffff));
    send_face(uniform_face(32'h8000_0000));
    send_face(uniform_face(32'hffff_ffff));
    send_face(uniform_face(32'h0001_0000));
    // first node at rest, unit normal
    fc = uniform_face(32'h0);
    fc.st[0] = '{32'h1_0000, 0, 0, 32'h2_0000};
    fc.st[1] = '{32'h2_0000, 32'h1_0000, 32'hffff_0000, 32'h4_0000};
    fc.nx = 32'h1_0000; fc.wsx = 32'h3_0000; fc.wsy = 32'h8000_0000;
    send_face(fc);
    // zero density with positive, negative and zero momentum
    fc.st[0] = '{32'h0, 32'h1_0000, 32'hffff_0000, 32'h1_0000};
    send_face(fc);
    fc.st[0] = '{32'h0, 32'h0, 32'h0, 32'h1_0000};
    send_face(fc);
    // negative density on the second node
    fc.st[1] = '{32'hffff_0000, 32'h5_0000, 32'h0, 32'h1_0000};
    send_face(fc);
    // tiny density, big momentum: velocity saturates
    fc.st[0] = '{32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    fc.st[1] = '{32'h1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_face(fc);
  endtask

  task automatic test_config_sweep;
    logic [31:0] alphas[5] = '{32'd0, 32'd65536, 32'd131071, 32'd32768, 32'd12345};
    logic [31:0] gammas[4] = '{32'd65536, 32'd131072, 32'd0, 32'd262143};
    logic [31:0] dts[4]    = '{32'd0, 32'h7fff_ffff, 32'd65536, 32'd1};
    for (int k = 0; k < 5; k++) begin
      drain();
      write_reg(swef_pkg::REG_MIX, alphas[k]);
      write_reg(swef_pkg::REG_GAMMA, gammas[k % 4]);
      write_reg(swef_pkg::REG_DT, dts[k % 4]);
      write_reg(swef_pkg::REG_MOVING, 32'(k & 1));
      repeat (30) send_face(rand_face());
    end
  endtask

  task automatic random_phase(int unsigned n_items);
    drain();
    write_reg(swef_pkg::REG_MIX, $urandom_range(65536));
    write_reg(swef_pkg::REG_GAMMA, $urandom_range(131072, 65536));
    write_reg(swef_pkg::REG_DT, $urandom_range(1 << 17));
    write_reg(swef_pkg::REG_MOVING, $urandom_range(1));
    repeat (n_items) send_face(rand_face());
  endtask

  task automatic test_random;
    src_idle_pct = 35; snk_stall_pct = 75;
    random_phase(200); random_phase(150);
    src_idle_pct = 75; snk_stall_pct = 35;
    random_phase(200); random_phase(150);
    src_idle_pct = 0; snk_stall_pct = 0;
    random_phase(200); random_phase(150);
  endtask

  // receiver blocks long enough that the pipe and queue fill and stall input
  task automatic test_backpressure;
    src_idle_pct = 0; snk_stall_pct = 0;
    drain();
    hold_cycles = 200;
    repeat (80) send_face(rand_face());
    // sender pauses until everything has come back
    drain();
    repeat (20) send_face(rand_face());
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/swef_pkg.sv
hdl/swef_front.sv
hdl/swef_fifo.sv
hdl/swef_div.sv
hdl/swef_back.sv
hdl/slip_wall_euler_flux_split.sv
test/tb.sv
